@@ design/rw_lock_priority_arbiter_assert.svh @@
// assertion macros shared by the arbiter rtl
`ifndef RW_LOCK_PRIORITY_ARBITER_ASSERT_SVH
`define RW_LOCK_PRIORITY_ARBITER_ASSERT_SVH

// same-cycle implication, idle during reset
`define RLPA_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rlpa assertion failed");

// next-cycle implication, idle during reset
`define RLPA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rlpa assertion failed");

`endif

@@ design/rlpa_pkg.sv @@
// types and constants of the reader/writer lock arbiter
package rlpa_pkg;

  // command codes
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_REQUEST = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_NOT_FOUND   = 3'd1,
    STS_TABLE_FULL  = 3'd2,
    STS_QUEUE_FULL  = 3'd3,
    STS_BUSY        = 3'd4,
    STS_USER_ABSENT = 3'd5
  } status_t;

  // priority modes; the spare code acts as explicit
  localparam logic [1:0] MODE_EXPLICIT  = 2'd0;
  localparam logic [1:0] MODE_ABOVE_MAX = 2'd1;
  localparam logic [1:0] MODE_BELOW_MIN = 2'd2;
  localparam logic [1:0] MODE_SPARE     = 2'd3;

  // access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // priority limits
  localparam logic signed [15:0] PRI_MAX = 16'sh7fff;
  localparam logic signed [15:0] PRI_MIN = 16'sh8000;

  // grants per command
  localparam int RESULT_CAP = 16;
  localparam int KW         = 5;

  // waiting request in a heap
  typedef struct packed {
    logic signed [15:0] pri;
    logic [15:0]        user;
    logic               kind;
  } entry_t;

  // holder slot contents
  typedef struct packed {
    logic [15:0] user;
    logic        kind;
  } holder_t;

  localparam int ENTRY_W  = $bits(entry_t);
  localparam int HOLDER_W = $bits(holder_t);

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_RQ_PRI,
    ST_SU0,
    ST_SU1,
    ST_G0,
    ST_G1,
    ST_G2,
    ST_SD0,
    ST_SD1,
    ST_SD2,
    ST_SU_LD,
    ST_SU_LD2,
    ST_HS_RD,
    ST_HS_CMP,
    ST_RL_TOP,
    ST_RL_CHK,
    ST_WS_RD,
    ST_WS_CMP,
    ST_WS_LAST,
    ST_FIN
  } state_t;

endpackage

@@ design/rw_lock_priority_arbiter.sv @@
// reader/writer lock arbiter: resource table, waiting heaps and holder slots
// A command is taken when start is high and busy is low, and busy stays high until its
// last result word has been shown. Each command gives one result word, or one word per
// grant (at most 16), each shown for a single cycle on out_valid with out_last on the
// final one; the receiver cannot stall, so words must be taken as they appear. Add and
// remove pass through dispatch and the final state, and the next command can be taken in
// the cycle their word is shown. A request computes its priority and sifts up the heap,
// then grants when the resource was idle. A grant takes the heap top into a free holder
// slot and sifts down. A release scans the holder slots, comparing only occupied ones,
// then either grants or scans the waiting heap for the user and re-sifts it. The heap
// and holder memories have a single read port each, read one word per cycle.
`include "rw_lock_priority_arbiter_assert.svh"
module rw_lock_priority_arbiter
  import rlpa_pkg::*;
#(
  parameter int RESOURCE_SLOTS = 8,
  parameter int QUEUE_DEPTH    = 16,
  parameter int HOLDER_SLOTS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic [15:0]        in_resource_id,
  input  logic [15:0]        in_user_id,
  input  logic signed [15:0] in_priority_req,
  input  logic [1:0]         in_priority_mode,
  input  logic               in_access_kind,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic               out_grant_valid,
  output logic [15:0]        out_granted_user,
  output logic               out_granted_kind,
  output logic signed [15:0] out_granted_priority,
  output logic               out_last
);

  localparam int SW   = (RESOURCE_SLOTS > 1) ? $clog2(RESOURCE_SLOTS) : 1;
  localparam int QW   = $clog2(QUEUE_DEPTH);
  localparam int IW   = QW + 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int HW   = (HOLDER_SLOTS > 1) ? $clog2(HOLDER_SLOTS) : 1;
  localparam int HCW  = $clog2(HOLDER_SLOTS + 1);
  localparam int HDEP = RESOURCE_SLOTS * QUEUE_DEPTH;
  localparam int ODEP = RESOURCE_SLOTS * HOLDER_SLOTS;
  localparam int HAW  = (HDEP > 1) ? $clog2(HDEP) : 1;
  localparam int OAW  = (ODEP > 1) ? $clog2(ODEP) : 1;

  // resource table
  logic                    sv_r   [RESOURCE_SLOTS];
  logic [15:0]             srid_r [RESOURCE_SLOTS];
  logic [CW-1:0]           qc_r   [RESOURCE_SLOTS];
  logic signed [15:0]      low_r  [RESOURCE_SLOTS];
  logic [HOLDER_SLOTS-1:0] hv_r   [RESOURCE_SLOTS];

  // table write controls
  logic                    sv_we, sv_wd, srid_we, qc_we, low_we, hv_we;
  logic [CW-1:0]           qc_wd;
  logic signed [15:0]      low_wd;
  logic [HOLDER_SLOTS-1:0] hv_wd;

  // sequencer and command registers
  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [15:0]        rid_r, rid_nxt, uid_r, uid_nxt;
  logic signed [15:0] preq_r, preq_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic               kind_r, kind_nxt;
  logic [SW-1:0]      s_r, s_nxt;
  logic               hit_r, hit_nxt, fok_r, fok_nxt;
  status_t            status_r, status_nxt;
  logic               idle_r, idle_nxt, loop_r, loop_nxt, first_r, first_nxt;
  logic               rm_r, rm_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [IW-1:0]      ix_r, ix_nxt;
  logic [QW-1:0]      i0_r, i0_nxt;
  logic [HCW-1:0]     h_r, h_nxt;
  logic [HW-1:0]      gh_r, gh_nxt;
  entry_t             cur_r, cur_nxt, top_r, top_nxt, lft_r, lft_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  entry_t             pend_r, pend_nxt;

  // result word registers
  logic               ov_r, ov_nxt, olast_r, olast_nxt, ogv_r, ogv_nxt, okind_r, okind_nxt;
  status_t            osts_r, osts_nxt;
  logic [15:0]        ouser_r, ouser_nxt;
  logic signed [15:0] opri_r, opri_nxt;

  // memory ports
  logic                heap_we;
  logic [HAW-1:0]      heap_waddr, heap_raddr;
  logic [ENTRY_W-1:0]  heap_wdata, heap_rdata;
  logic                hold_we;
  logic [OAW-1:0]      hold_waddr, hold_raddr;
  logic [HOLDER_W-1:0] hold_wdata, hold_rdata;

  rlpa_ram #(.W(ENTRY_W), .DEPTH(HDEP)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  rlpa_ram #(.W(HOLDER_W), .DEPTH(ODEP)) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (hold_waddr),
    .wdata (hold_wdata),
    .raddr (hold_raddr),
    .rdata (hold_rdata)
  );

  // heap address of an index in the current resource
  function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s, input logic [QW-1:0] idx);
    haddr = HAW'(int'(s) * QUEUE_DEPTH + int'(idx));
  endfunction

  // lookup of the addressed resource and of the first free slot
  logic          lk_hit, lk_free;
  logic [SW-1:0] lk_sidx, lk_fidx;
  always_comb begin
    lk_hit  = 1'b0;
    lk_free = 1'b0;
    lk_sidx = '0;
    lk_fidx = '0;
    for (int j = 0; j < RESOURCE_SLOTS; j++) begin
      if (!lk_hit && sv_r[j] && srid_r[j] == in_resource_id) begin
        lk_hit  = 1'b1;
        lk_sidx = SW'(j);
      end
      if (!lk_free && !sv_r[j]) begin
        lk_free = 1'b1;
        lk_fidx = SW'(j);
      end
    end
  end

  // first free holder slot of the current resource
  logic [HOLDER_SLOTS-1:0] row;
  logic                    fh_ok;
  logic [HW-1:0]           fh;
  always_comb begin
    row   = hv_r[s_r];
    fh_ok = 1'b0;
    fh    = '0;
    for (int j = 0; j < HOLDER_SLOTS; j++) begin
      if (!fh_ok && !row[j]) begin
        fh_ok = 1'b1;
        fh    = HW'(j);
      end
    end
  end

  // heap index arithmetic
  logic [CW-1:0]      qc;
  logic [IW+1:0]      lft_i, rgt_i, qce;
  logic [IW-1:0]      par_i;
  entry_t             hrd;
  holder_t            ord;
  logic signed [15:0] pm, pp;
  entry_t             child;
  logic [IW-1:0]      cidx;

  assign qc    = qc_r[s_r];
  assign lft_i = {1'b0, ix_r, 1'b1};
  assign rgt_i = lft_i + (IW+2)'(1);
  assign qce   = (IW+2)'(qc);
  assign par_i = (ix_r - IW'(1)) >> 1;
  assign hrd   = entry_t'(heap_rdata);
  assign ord   = holder_t'(hold_rdata);

  // sequencer next state and datapath
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    rid_nxt      = rid_r;
    uid_nxt      = uid_r;
    preq_nxt     = preq_r;
    mode_nxt     = mode_r;
    kind_nxt     = kind_r;
    s_nxt        = s_r;
    hit_nxt      = hit_r;
    fok_nxt      = fok_r;
    status_nxt   = status_r;
    idle_nxt     = idle_r;
    loop_nxt     = loop_r;
    first_nxt    = first_r;
    rm_nxt       = rm_r;
    k_nxt        = k_r;
    ix_nxt       = ix_r;
    i0_nxt       = i0_r;
    h_nxt        = h_r;
    gh_nxt       = gh_r;
    cur_nxt      = cur_r;
    top_nxt      = top_r;
    lft_nxt      = lft_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    ov_nxt       = 1'b0;
    olast_nxt    = olast_r;
    ogv_nxt      = ogv_r;
    okind_nxt    = okind_r;
    osts_nxt     = osts_r;
    ouser_nxt    = ouser_r;
    opri_nxt     = opri_r;
    sv_we        = 1'b0;
    sv_wd        = 1'b0;
    srid_we      = 1'b0;
    qc_we        = 1'b0;
    qc_wd        = qc;
    low_we       = 1'b0;
    low_wd       = low_r[s_r];
    hv_we        = 1'b0;
    hv_wd        = row;
    heap_we      = 1'b0;
    heap_waddr   = haddr(s_r, ix_r[QW-1:0]);
    heap_wdata   = cur_r;
    heap_raddr   = haddr(s_r, '0);
    hold_we      = 1'b0;
    hold_waddr   = OAW'(int'(s_r) * HOLDER_SLOTS + int'(gh_r));
    hold_wdata   = {top_r.user, top_r.kind};
    hold_raddr   = OAW'(int'(s_r) * HOLDER_SLOTS + int'(h_r[HW-1:0]));
    pm           = '0;
    pp           = preq_r;
    child        = lft_r;
    cidx         = lft_i[IW-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt       = op_t'(in_op);
          rid_nxt      = in_resource_id;
          uid_nxt      = in_user_id;
          preq_nxt     = in_priority_req;
          mode_nxt     = in_priority_mode;
          kind_nxt     = in_access_kind;
          hit_nxt      = lk_hit;
          fok_nxt      = lk_free;
          s_nxt        = lk_hit ? lk_sidx : lk_fidx;
          status_nxt   = STS_OK;
          k_nxt        = '0;
          loop_nxt     = 1'b0;
          rm_nxt       = 1'b0;
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_DISP;
        end
      end

      ST_DISP: begin
        state_nxt = ST_FIN;
        if (op_r == OP_ADD) begin
          if (!hit_r) begin
            if (fok_r) begin
              sv_we   = 1'b1;
              sv_wd   = 1'b1;
              srid_we = 1'b1;
              qc_we   = 1'b1;
              qc_wd   = '0;
              low_we  = 1'b1;
              low_wd  = '0;
              hv_we   = 1'b1;
              hv_wd   = '0;
            end else begin
              status_nxt = STS_TABLE_FULL;
            end
          end
        end else if (!hit_r) begin
          status_nxt = STS_NOT_FOUND;
        end else if (op_r == OP_REMOVE) begin
          if (qc != '0) begin
            status_nxt = STS_BUSY;
          end else begin
            sv_we = 1'b1;
          end
        end else if (op_r == OP_REQUEST) begin
          if (qc >= CW'(QUEUE_DEPTH)) begin
            status_nxt = STS_QUEUE_FULL;
          end else begin
            idle_nxt  = (qc == '0) && (row == '0);
            state_nxt = ST_RQ_PRI;
          end
        end else begin
          h_nxt     = '0;
          state_nxt = ST_HS_RD;
        end
      end

      // priority of the new request, then insert at the bottom
      ST_RQ_PRI: begin
        pm = (qc != '0) ? hrd.pri : 16'sd0;
        if (mode_r == MODE_ABOVE_MAX) begin
          pp = (pm == PRI_MAX) ? PRI_MAX : pm + 16'sd1;
        end else if (mode_r == MODE_BELOW_MIN) begin
          pp = (low_r[s_r] == PRI_MIN) ? PRI_MIN : low_r[s_r] - 16'sd1;
        end
        if (pp < low_r[s_r]) begin
          low_we = 1'b1;
          low_wd = pp;
        end
        cur_nxt   = '{pri: pp, user: uid_r, kind: kind_r};
        ix_nxt    = IW'(qc);
        qc_we     = 1'b1;
        qc_wd     = qc + CW'(1);
        state_nxt = ST_SU0;
      end

      // sift up: hole climbs while the parent is smaller
      ST_SU0: begin
        if (ix_r == '0) begin
          heap_we = 1'b1;
          if (op_r == OP_REQUEST && idle_r) begin
            state_nxt = ST_G0;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          heap_raddr = haddr(s_r, par_i[QW-1:0]);
          state_nxt  = ST_SU1;
        end
      end

      ST_SU1: begin
        heap_we = 1'b1;
        if (cur_r.pri > hrd.pri) begin
          heap_wdata = hrd;
          ix_nxt     = par_i;
          state_nxt  = ST_SU0;
        end else if (op_r == OP_REQUEST && idle_r) begin
          state_nxt = ST_G0;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // grant: top of heap into a free holder slot
      ST_G0: begin
        if (qc != '0 && k_r < KW'(RESULT_CAP) && fh_ok) begin
          gh_nxt    = fh;
          state_nxt = ST_G1;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      ST_G1: begin
        top_nxt    = hrd;
        qc_we      = 1'b1;
        qc_wd      = qc - CW'(1);
        heap_raddr = haddr(s_r, qc_wd[QW-1:0]);
        state_nxt  = ST_G2;
      end

      ST_G2: begin
        cur_nxt         = hrd;
        hold_we         = 1'b1;
        hv_we           = 1'b1;
        hv_wd[gh_r]     = 1'b1;
        k_nxt           = k_r + KW'(1);
        if (pend_vld_r) begin
          ov_nxt    = 1'b1;
          olast_nxt = 1'b0;
          ogv_nxt   = 1'b1;
          osts_nxt  = STS_OK;
          ouser_nxt = pend_r.user;
          okind_nxt = pend_r.kind;
          opri_nxt  = pend_r.pri;
        end
        pend_nxt     = top_r;
        pend_vld_nxt = 1'b1;
        ix_nxt       = '0;
        state_nxt    = ST_SD0;
      end

      // sift down: hole descends while a child is larger
      ST_SD0: begin
        if (lft_i >= qce) begin
          heap_we = 1'b1;
          if (rm_r) begin
            state_nxt = ST_SU_LD;
          end else if (loop_r) begin
            state_nxt = ST_RL_TOP;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          heap_raddr = haddr(s_r, lft_i[QW-1:0]);
          state_nxt  = ST_SD1;
        end
      end

      ST_SD1, ST_SD2: begin
        if (state_r == ST_SD1) begin
          lft_nxt = hrd;
          child   = hrd;
        end else if (hrd.pri > lft_r.pri) begin
          child = hrd;
          cidx  = rgt_i[IW-1:0];
        end
        if (state_r == ST_SD1 && rgt_i < qce) begin
          heap_raddr = haddr(s_r, rgt_i[QW-1:0]);
          state_nxt  = ST_SD2;
        end else begin
          heap_we = 1'b1;
          if (child.pri > cur_r.pri) begin
            heap_wdata = child;
            ix_nxt     = cidx;
            state_nxt  = ST_SD0;
          end else if (rm_r) begin
            state_nxt = ST_SU_LD;
          end else if (loop_r) begin
            state_nxt = ST_RL_TOP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      // reload the removed position before sifting up
      ST_SU_LD: begin
        heap_raddr = haddr(s_r, i0_r);
        ix_nxt     = IW'(i0_r);
        state_nxt  = ST_SU_LD2;
      end

      ST_SU_LD2: begin
        cur_nxt   = hrd;
        state_nxt = ST_SU0;
      end

      // search holder slots for the releasing user
      ST_HS_RD: begin
        if (h_r == HCW'(HOLDER_SLOTS)) begin
          ix_nxt    = '0;
          state_nxt = ST_WS_RD;
        end else if (row[h_r[HW-1:0]]) begin
          state_nxt = ST_HS_CMP;
        end else begin
          h_nxt = h_r + HCW'(1);
        end
      end

      ST_HS_CMP: begin
        if (ord.user == uid_r) begin
          hv_we                 = 1'b1;
          hv_wd[h_r[HW-1:0]]    = 1'b0;
          first_nxt             = 1'b1;
          state_nxt             = ST_RL_TOP;
        end else begin
          h_nxt     = h_r + HCW'(1);
          state_nxt = ST_HS_RD;
        end
      end

      // decide on the next grant after a release
      ST_RL_TOP: begin
        state_nxt = (qc == '0) ? ST_FIN : ST_RL_CHK;
      end

      ST_RL_CHK: begin
        if (first_r) begin
          first_nxt = 1'b0;
          loop_nxt  = (hrd.kind == KIND_READ);
          state_nxt = ST_G0;
        end else if (hrd.kind == KIND_READ) begin
          state_nxt = ST_G0;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // search the heap for a waiting request of the user
      ST_WS_RD: begin
        if (ix_r == IW'(qc)) begin
          status_nxt = STS_USER_ABSENT;
          state_nxt  = ST_FIN;
        end else begin
          heap_raddr = haddr(s_r, ix_r[QW-1:0]);
          state_nxt  = ST_WS_CMP;
        end
      end

      ST_WS_CMP: begin
        if (hrd.user == uid_r) begin
          i0_nxt     = ix_r[QW-1:0];
          qc_we      = 1'b1;
          qc_wd      = qc - CW'(1);
          heap_raddr = haddr(s_r, qc_wd[QW-1:0]);
          state_nxt  = ST_WS_LAST;
        end else begin
          ix_nxt    = ix_r + IW'(1);
          state_nxt = ST_WS_RD;
        end
      end

      ST_WS_LAST: begin
        cur_nxt = hrd;
        if (CW'(i0_r) < qc) begin
          rm_nxt    = 1'b1;
          ix_nxt    = IW'(i0_r);
          state_nxt = ST_SD0;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // final result word of the command
      ST_FIN: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        if (pend_vld_r) begin
          ogv_nxt   = 1'b1;
          osts_nxt  = STS_OK;
          ouser_nxt = pend_r.user;
          okind_nxt = pend_r.kind;
          opri_nxt  = pend_r.pri;
        end else begin
          ogv_nxt   = 1'b0;
          osts_nxt  = status_r;
          ouser_nxt = '0;
          okind_nxt = 1'b0;
          opri_nxt  = '0;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ov_r       <= 1'b0;
      pend_vld_r <= 1'b0;
      k_r        <= '0;
      for (int j = 0; j < RESOURCE_SLOTS; j++) begin
        sv_r[j]  <= 1'b0;
        qc_r[j]  <= '0;
        low_r[j] <= '0;
        hv_r[j]  <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      ov_r       <= ov_nxt;
      pend_vld_r <= pend_vld_nxt;
      k_r        <= k_nxt;
      if (sv_we) begin
        sv_r[s_r] <= sv_wd;
      end
      if (qc_we) begin
        qc_r[s_r] <= qc_wd;
      end
      if (low_we) begin
        low_r[s_r] <= low_wd;
      end
      if (hv_we) begin
        hv_r[s_r] <= hv_wd;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (srid_we) begin
      srid_r[s_r] <= rid_r;
    end
    op_r      <= op_nxt;
    rid_r     <= rid_nxt;
    uid_r     <= uid_nxt;
    preq_r    <= preq_nxt;
    mode_r    <= mode_nxt;
    kind_r    <= kind_nxt;
    s_r       <= s_nxt;
    hit_r     <= hit_nxt;
    fok_r     <= fok_nxt;
    status_r  <= status_nxt;
    idle_r    <= idle_nxt;
    loop_r    <= loop_nxt;
    first_r   <= first_nxt;
    rm_r      <= rm_nxt;
    ix_r      <= ix_nxt;
    i0_r      <= i0_nxt;
    h_r       <= h_nxt;
    gh_r      <= gh_nxt;
    cur_r     <= cur_nxt;
    top_r     <= top_nxt;
    lft_r     <= lft_nxt;
    pend_r    <= pend_nxt;
    olast_r   <= olast_nxt;
    ogv_r     <= ogv_nxt;
    okind_r   <= okind_nxt;
    osts_r    <= osts_nxt;
    ouser_r   <= ouser_nxt;
    opri_r    <= opri_nxt;
  end

  // ports
  assign busy                 = (state_r != ST_IDLE);
  assign out_valid            = ov_r;
  assign out_status           = osts_r;
  assign out_grant_valid      = ogv_r;
  assign out_granted_user     = ouser_r;
  assign out_granted_kind     = okind_r;
  assign out_granted_priority = opri_r;
  assign out_last             = olast_r;

  // checks
  `RLPA_ASSERT_NEXT(a_accept_dispatch, clk, rst_n, start && !busy, state_r == ST_DISP)
  `RLPA_ASSERT_NOW(a_last_ends_cmd, clk, rst_n, ov_r && olast_r, state_r == ST_IDLE)
  `RLPA_ASSERT_NOW(a_mid_word_busy, clk, rst_n, ov_r && !olast_r, state_r != ST_IDLE && ogv_r)
  `RLPA_ASSERT_NOW(a_grant_cap, clk, rst_n, 1'b1, k_r <= KW'(RESULT_CAP))
  `RLPA_ASSERT_NOW(a_grant_ok, clk, rst_n, ov_r && ogv_r, osts_r == STS_OK)

endmodule

@@ design/rlpa_ram.sv @@
// simple dual port memory with registered read
module rlpa_ram #(
  parameter int W     = 33,
  parameter int DEPTH = 128,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ bench/testbench.sv @@
// self-checking testbench of the reader/writer lock arbiter
module testbench
  import rlpa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;
  localparam int QDEPTH = 16;
  localparam int NHOLD = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  // one result word
  typedef struct {
    status_t            status;
    logic               grant_valid;
    logic [15:0]        user;
    logic               kind;
    logic signed [15:0] pri;
    logic               last;
  } grant_word_t;

  // expected words in order, with mismatch bookkeeping
  class grant_scoreboard;
    grant_word_t pending[$];
    int errors;

    function void note(grant_word_t w[$]);
      foreach (w[i]) pending = {pending, w[i]};
    endfunction

    function void check(grant_word_t act);
      grant_word_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word status=%0d user=%0d", act.status, act.user);
        return;
      end
      exp = pending.pop_front();
      if (exp.status != act.status || exp.grant_valid != act.grant_valid ||
          exp.user != act.user || exp.kind != act.kind || exp.pri != act.pri ||
          exp.last != act.last) begin
        errors++;
        if (errors <= 10) begin
          $display("word differs: exp st=%0d g=%0d u=%0d k=%0d p=%0d l=%0d",
                   exp.status, exp.grant_valid, exp.user, exp.kind, exp.pri, exp.last);
          $display("              act st=%0d g=%0d u=%0d k=%0d p=%0d l=%0d",
                   act.status, act.grant_valid, act.user, act.kind, act.pri, act.last);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [15:0] in_resource_id = '0;
  logic [15:0] in_user_id = '0;
  logic signed [15:0] in_priority_req = '0;
  logic [1:0] in_priority_mode = '0;
  logic in_access_kind = 1'b0;
  logic out_valid;
  logic [2:0] out_status;
  logic out_grant_valid;
  logic [15:0] out_granted_user;
  logic out_granted_kind;
  logic signed [15:0] out_granted_priority;
  logic out_last;

  always #2 clk = ~clk;

  rw_lock_priority_arbiter i_dut (
    .clk, .rst_n, .start, .busy, .in_op, .in_resource_id, .in_user_id,
    .in_priority_req, .in_priority_mode, .in_access_kind, .out_valid, .out_status,
    .out_grant_valid, .out_granted_user, .out_granted_kind, .out_granted_priority,
    .out_last
  );

  // predictor state
  logic               tbl_valid [NSLOT];
  logic [15:0]        tbl_rid [NSLOT];
  int                 wait_cnt [NSLOT];
  int                 floor_pri [NSLOT];
  entry_t             waiters [NSLOT][QDEPTH];
  logic               hold_valid [NSLOT][NHOLD];
  logic [15:0]        hold_user [NSLOT][NHOLD];

  grant_scoreboard sb = new();
  int idle_cycles = 0;
  logic [15:0] rid_pool [4] = '{16'h0000, 16'hffff, 16'h1234, 16'h8001};

  function automatic int lookup(logic [15:0] rid);
    for (int s = 0; s < NSLOT; s++)
      if (tbl_valid[s] && tbl_rid[s] == rid) return s;
    return -1;
  endfunction

  function automatic void swap_w(int s, int a, int b);
    entry_t t;
    t = waiters[s][a];
    waiters[s][a] = waiters[s][b];
    waiters[s][b] = t;
  endfunction

  function automatic void heap_down(int s, int i);
    int l, c;
    forever begin
      l = 2 * i + 1;
      if (l >= wait_cnt[s]) break;
      c = l;
      if (l + 1 < wait_cnt[s] && waiters[s][l + 1].pri > waiters[s][l].pri) c = l + 1;
      if (waiters[s][c].pri > waiters[s][i].pri) begin
        swap_w(s, c, i);
        i = c;
      end else break;
    end
  endfunction

  function automatic void heap_up(int s, int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (waiters[s][i].pri > waiters[s][p].pri) begin
        swap_w(s, i, p);
        i = p;
      end else break;
    end
  endfunction

  function automatic int open_holder(int s);
    for (int h = 0; h < NHOLD; h++)
      if (!hold_valid[s][h]) return h;
    return -1;
  endfunction

  // move the heap top into a holder slot, adding its grant word
  function automatic bit hand_over(int s, ref grant_word_t w[$]);
    int h;
    entry_t e;
    grant_word_t g;
    if (wait_cnt[s] == 0 || w.size() >= RESULT_CAP) return 0;
    h = open_holder(s);
    if (h < 0) return 0;
    e = waiters[s][0];
    wait_cnt[s]--;
    waiters[s][0] = waiters[s][wait_cnt[s]];
    heap_down(s, 0);
    hold_valid[s][h] = 1'b1;
    hold_user[s][h] = e.user;
    g.status = STS_OK; g.grant_valid = 1'b1; g.user = e.user; g.kind = e.kind;
    g.pri = e.pri; g.last = 1'b0;
    w = {w, g};
    return 1;
  endfunction

  // expected words of one command
  function automatic void predict_command(op_t op, logic [15:0] rid, logic [15:0] uid,
                                          logic signed [15:0] preq, logic [1:0] mode,
                                          logic kind, ref grant_word_t w[$]);
    int s, f, found, i, p, m;
    bit idle;
    status_t st;
    grant_word_t g;
    s = lookup(rid);
    st = STS_OK;
    w = {};
    if (op == OP_ADD) begin
      if (s < 0) begin
        for (f = 0; f < NSLOT && tbl_valid[f]; f++) ;
        if (f >= NSLOT) st = STS_TABLE_FULL;
        else begin
          tbl_valid[f] = 1'b1; tbl_rid[f] = rid; wait_cnt[f] = 0; floor_pri[f] = 0;
          for (int h = 0; h < NHOLD; h++) hold_valid[f][h] = 1'b0;
        end
      end
    end else if (s < 0) st = STS_NOT_FOUND;
    else if (op == OP_REMOVE) begin
      if (wait_cnt[s] != 0) st = STS_BUSY;
      else tbl_valid[s] = 1'b0;
    end else if (op == OP_REQUEST) begin
      if (wait_cnt[s] >= QDEPTH) st = STS_QUEUE_FULL;
      else begin
        idle = wait_cnt[s] == 0 && open_holder(s) == 0;
        for (int h = 0; h < NHOLD; h++) if (hold_valid[s][h]) idle = 0;
        p = preq;
        if (mode == MODE_ABOVE_MAX) begin
          m = wait_cnt[s] ? int'(waiters[s][0].pri) : 0;
          p = (m >= 32767) ? 32767 : m + 1;
        end else if (mode == MODE_BELOW_MIN) begin
          m = floor_pri[s];
          p = (m <= -32768) ? -32768 : m - 1;
        end
        if (p < floor_pri[s]) floor_pri[s] = p;
        waiters[s][wait_cnt[s]].pri = p[15:0];
        waiters[s][wait_cnt[s]].user = uid;
        waiters[s][wait_cnt[s]].kind = kind;
        wait_cnt[s]++;
        heap_up(s, wait_cnt[s] - 1);
        if (idle) void'(hand_over(s, w));
      end
    end else begin
      found = -1;
      for (int h = 0; h < NHOLD; h++)
        if (hold_valid[s][h] && hold_user[s][h] == uid) begin
          found = h;
          break;
        end
      if (found >= 0) begin
        hold_valid[s][found] = 1'b0;
        if (wait_cnt[s] != 0) begin
          if (waiters[s][0].kind != KIND_READ) void'(hand_over(s, w));
          else
            while (wait_cnt[s] != 0 && waiters[s][0].kind == KIND_READ)
              if (!hand_over(s, w)) break;
        end
      end else begin
        for (i = 0; i < wait_cnt[s]; i++) if (waiters[s][i].user == uid) break;
        if (i >= wait_cnt[s]) st = STS_USER_ABSENT;
        else begin
          wait_cnt[s]--;
          waiters[s][i] = waiters[s][wait_cnt[s]];
          if (i < wait_cnt[s]) begin
            heap_down(s, i);
            heap_up(s, i);
          end
        end
      end
    end
    if (w.size() == 0) begin
      g.status = st; g.grant_valid = 1'b0; g.user = '0; g.kind = 1'b0; g.pri = '0;
      w = {w, g};
    end
    w[w.size() - 1].last = 1'b1;
  endfunction

  // issue one command word and note its expected results
  task automatic send_word(op_t op, logic [15:0] rid, logic [15:0] uid,
                           logic signed [15:0] preq, logic [1:0] mode, logic kind);
    grant_word_t w[$];
    start <= 1'b1;
    in_op <= op; in_resource_id <= rid; in_user_id <= uid;
    in_priority_req <= preq; in_priority_mode <= mode; in_access_kind <= kind;
    do @(posedge clk); while (busy);
    predict_command(op, rid, uid, preq, mode, kind, w);
    sb.note(w);
    @(negedge clk);
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  // random command, mostly on a few live resources with narrow user range
  task automatic send_random();
    int r;
    op_t op;
    logic [15:0] rid, uid;
    r = $urandom_range(0, 99);
    op = r < 10 ? OP_ADD : r < 15 ? OP_REMOVE : r < 65 ? OP_REQUEST : OP_RELEASE;
    rid = ($urandom_range(0, 19) == 0) ? 16'($urandom) : rid_pool[$urandom_range(0, 3)];
    uid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    send_word(op, rid, uid, 16'($urandom), 2'($urandom), 1'($urandom));
  endtask

  // check every result word at the rising edge
  always @(posedge clk) begin
    grant_word_t a;
    if (rst_n && out_valid) begin
      a.status = status_t'(out_status); a.grant_valid = out_grant_valid;
      a.user = out_granted_user; a.kind = out_granted_kind;
      a.pri = out_granted_priority; a.last = out_last;
      sb.check(a);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("rw_lock_priority_arbiter: mismatch");
      $finish;
    end
  end

  initial begin
    int burst;
    for (int s = 0; s < NSLOT; s++) begin
      tbl_valid[s] = 1'b0; wait_cnt[s] = 0; floor_pri[s] = 0;
      for (int h = 0; h < NHOLD; h++) hold_valid[s][h] = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: unknown resource, add, requests with all modes and saturation
    send_word(OP_REQUEST, 16'h1234, 16'd1, 16'sd0, MODE_EXPLICIT, KIND_READ);
    send_word(OP_ADD, 16'h1234, 16'd0, 16'sd0, MODE_EXPLICIT, KIND_READ);
    send_word(OP_ADD, 16'h1234, 16'd0, 16'sd0, MODE_EXPLICIT, KIND_READ);
    send_word(OP_REQUEST, 16'h1234, 16'd1, PRI_MAX, MODE_EXPLICIT, KIND_WRITE);
    send_word(OP_REQUEST, 16'h1234, 16'd2, PRI_MAX, MODE_EXPLICIT, KIND_READ);
    send_word(OP_REQUEST, 16'h1234, 16'd3, 16'sd0, MODE_ABOVE_MAX, KIND_READ);
    send_word(OP_REQUEST, 16'h1234, 16'hffff, PRI_MIN, MODE_EXPLICIT, KIND_READ);
    send_word(OP_REQUEST, 16'h1234, 16'd5, 16'sd0, MODE_BELOW_MIN, KIND_READ);
    send_word(OP_REQUEST, 16'h1234, 16'd6, 16'sd7, MODE_SPARE, KIND_READ);
    send_word(OP_REMOVE, 16'h1234, 16'd0, 16'sd0, MODE_EXPLICIT, KIND_READ);
    send_word(OP_RELEASE, 16'h1234, 16'd99, 16'sd0, MODE_EXPLICIT, KIND_READ);
    send_word(OP_RELEASE, 16'h1234, 16'd6, 16'sd0, MODE_EXPLICIT, KIND_READ);
    send_word(OP_RELEASE, 16'h1234, 16'd1, 16'sd0, MODE_EXPLICIT, KIND_READ);
    drain_results();
    // fill the table and one heap
    for (int i = 0; i < 9; i++)
      send_word(OP_ADD, 16'(16'h0100 + i), 16'd0, 16'sd0, MODE_EXPLICIT, KIND_READ);
    for (int i = 0; i < 18; i++)
      send_word(OP_REQUEST, 16'h0100, 16'(i), 16'($urandom), 2'($urandom), KIND_READ);
    drain_results();
    // release the holder: reader burst until holders fill
    send_word(OP_RELEASE, 16'h0100, 16'd0, 16'sd0, MODE_EXPLICIT, KIND_READ);
    for (int i = 0; i < 8; i++)
      send_word(OP_REMOVE, 16'(16'h0100 + i), 16'd0, 16'sd0, MODE_EXPLICIT, KIND_READ);
    drain_results();
    // random bursts
    for (int n = 0; n < 100;) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++) begin
        send_random();
        n++;
      end
      if ($urandom_range(0, 3) == 0) drain_results();
      else pause_sender($urandom_range(1, 30));
    end
    drain_results();
    repeat (400) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("rw_lock_priority_arbiter: match");
    else
      $display("rw_lock_priority_arbiter: mismatch");
    $finish;
  end
endmodule
